### hdl/rtgc_pkg.sv
// ----------------------------------------------------------------------------
// Rank to grid coordinates: shared package
// Field widths, register indexes, trial-division constants and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rtgc_pkg;

  localparam int EXT_W     = 11;
  localparam int COORD_W   = 10;
  localparam int RANK_W    = 30;
  localparam int PROD_W    = 2 * EXT_W;
  localparam int SIZE_W    = 33;
  localparam int QUOT_W    = EXT_W;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_Z = 2'd2;

  localparam logic [EXT_W-1:0] EXT_ONE     = 11'd1;
  localparam logic [EXT_W-1:0] TRIAL_TWO   = 11'd2;
  localparam logic [EXT_W-1:0] TRIAL_THREE = 11'd3;
  localparam logic [EXT_W-1:0] TRIAL_FIVE  = 11'd5;
  localparam logic [EXT_W-1:0] PAIR_STEP   = 11'd2;
  localparam logic [EXT_W-1:0] WHEEL_STEP  = 11'd4;
  localparam logic [EXT_W-1:0] PRIME_FLOOR = 11'd4;

  typedef enum logic {
    SDIV_RESIDUE = 1'b0,
    SDIV_EXTENT  = 1'b1
  } sdiv_sel_t;

  typedef struct packed {
    logic      load;
    logic      size1;
    logic      size2;
    logic      check;
    logic      pick;
    logic      half;
    logic      sdiv_start;
    sdiv_sel_t sdiv_sel;
    logic      fstep;
    logic      fend;
    logic      capture_nq;
    logic      csize;
    logic      rdiv_start;
    logic      capture_hi;
    logic      mul;
    logic      update;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic too_large;
    logic size_one;
    logic d_is_two;
    logic try_ok;
    logic sdiv_done;
    logic rdiv_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### hdl/rank_to_grid_coordinates_core.sv
// ----------------------------------------------------------------------------
// Rank to grid coordinates
// Places a linear node rank in a 3-D grid by peeling off the largest prime
// factor of the largest extent, level by level.
// A flagged rank or a one-position grid goes straight to the output; otherwise
// each prime factor of the grid size takes a halving step per factor of two,
// odd trial divisions, an extent and a rank divide and a coordinate update.
// Throughput: one item at a time; the next input transfer can come in the same
// cycle in which out_valid first goes high.
// Reset: synchronous, active low; the extent registers return to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_to_grid_coordinates_core #(
  parameter int MAX_EXTENT = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rtgc_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [rtgc_pkg::EXT_W-1:0]       cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rtgc_pkg::RANK_W-1:0]      in_node_rank,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [rtgc_pkg::COORD_W-1:0]     out_coord_x,
  output logic      [rtgc_pkg::COORD_W-1:0]     out_coord_y,
  output logic      [rtgc_pkg::COORD_W-1:0]     out_coord_z,
  output logic                                  out_rank_too_large
);

  rtgc_pkg::cmd_t    cmd;
  rtgc_pkg::status_t status;

  rtgc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rtgc_datapath #(
    .MAX_EXTENT (MAX_EXTENT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_node_rank       (in_node_rank),
    .out_ready          (out_ready),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_coord_x        (out_coord_x),
    .out_coord_y        (out_coord_y),
    .out_coord_z        (out_coord_z),
    .out_rank_too_large (out_rank_too_large)
  );

endmodule

`default_nettype wire

### hdl/rtgc_div.sv
// ----------------------------------------------------------------------------
// Rank to grid coordinates: restoring divider
// Produces one quotient bit per cycle. The dividend must lie below the divisor
// shifted left by the quotient width.
// ----------------------------------------------------------------------------
`default_nettype none

module rtgc_div #(
  parameter int DIVIDEND_W = 11,
  parameter int DIVISOR_W  = 11,
  parameter int QUOT_W     = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic      [QUOT_W-1:0]     quot,
  output logic      [DIVIDEND_W-1:0] rem,
  output logic                       done
);

  localparam int CW    = DIVISOR_W + QUOT_W;
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [CW-1:0]     rem_r;
  logic [CW-1:0]     den_r;
  logic [QUOT_W-1:0] quot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;
  logic [CW-1:0]     diff;

  assign ge   = rem_r >= den_r;
  assign diff = rem_r - den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(QUOT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= CW'(dividend);
      den_r  <= CW'(divisor) << (QUOT_W - 1);
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff;
      end
      den_r  <= den_r >> 1;
      quot_r <= {quot_r[QUOT_W-2:0], ge};
    end
  end

  assign quot = quot_r;
  assign rem  = rem_r[DIVIDEND_W-1:0];
  assign done = done_r;

endmodule

`default_nettype wire

### hdl/rtgc_datapath.sv
// ----------------------------------------------------------------------------
// Rank to grid coordinates: datapath
// Holds the extent registers, working extents, rank, grid size and coordinates,
// the two dividers and the output register, and acts on controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rtgc_datapath #(
  parameter int MAX_EXTENT = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [rtgc_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [rtgc_pkg::EXT_W-1:0]          cfg_wdata,
  input  wire logic [rtgc_pkg::RANK_W-1:0]         in_node_rank,
  input  wire logic                                out_ready,
  input  wire rtgc_pkg::cmd_t                      cmd,
  output rtgc_pkg::status_t                        status,
  output logic                                     out_valid,
  output logic      [rtgc_pkg::COORD_W-1:0]        out_coord_x,
  output logic      [rtgc_pkg::COORD_W-1:0]        out_coord_y,
  output logic      [rtgc_pkg::COORD_W-1:0]        out_coord_z,
  output logic                                     out_rank_too_large
);

  localparam int EXT_W   = rtgc_pkg::EXT_W;
  localparam int COORD_W = rtgc_pkg::COORD_W;
  localparam int RANK_W  = rtgc_pkg::RANK_W;
  localparam int PROD_W  = rtgc_pkg::PROD_W;
  localparam int SIZE_W  = rtgc_pkg::SIZE_W;
  localparam int QUOT_W  = rtgc_pkg::QUOT_W;

  localparam logic [EXT_W-1:0] EXT_CAP =
    (MAX_EXTENT >= (1 << EXT_W) - 1) ? {EXT_W{1'b1}} : EXT_W'(MAX_EXTENT);

  typedef enum logic [2:0] {
    AXIS_X = 3'b001,
    AXIS_Y = 3'b010,
    AXIS_Z = 3'b100
  } axis_t;

  logic [EXT_W-1:0]   cfg_x_r, cfg_y_r, cfg_z_r;
  logic [EXT_W-1:0]   clamp_x, clamp_y, clamp_z;
  logic [EXT_W-1:0]   ext_x_r, ext_y_r, ext_z_r;
  logic [EXT_W-1:0]   crd_x_r, crd_y_r, crd_z_r;
  logic [RANK_W-1:0]  rank_r;
  logic [SIZE_W-1:0]  size_r;
  logic [SIZE_W-1:0]  csize_r;
  logic [PROD_W-1:0]  prod_r;
  axis_t              axis_r;
  logic [EXT_W-1:0]   n_r;
  logic [EXT_W-1:0]   p_r;
  logic [EXT_W-1:0]   d_r;
  logic               dhi_r;
  logic [EXT_W-1:0]   nq_r;
  logic [QUOT_W-1:0]  hi_r;
  logic [EXT_W-1:0]   step_r;
  logic               flag_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] out_x_r, out_y_r, out_z_r;
  logic               out_flag_r;

  axis_t              pick_axis;
  logic [EXT_W-1:0]   pick_ext, pick_oa, pick_ob;
  logic [EXT_W-1:0]   cur_ext;
  logic [PROD_W-1:0]  trial_sq;
  logic [PROD_W-1:0]  step_prod;
  logic               too_large;

  logic [EXT_W-1:0]   sdiv_dividend, sdiv_divisor;
  logic [QUOT_W-1:0]  sdiv_quot;
  logic [EXT_W-1:0]   sdiv_rem;
  logic               sdiv_done;
  logic [QUOT_W-1:0]  rdiv_quot;
  logic [SIZE_W-1:0]  rdiv_rem;
  logic               rdiv_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_x_r <= rtgc_pkg::EXT_ONE;
      cfg_y_r <= rtgc_pkg::EXT_ONE;
      cfg_z_r <= rtgc_pkg::EXT_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        rtgc_pkg::REG_EXTENT_X: cfg_x_r <= cfg_wdata;
        rtgc_pkg::REG_EXTENT_Y: cfg_y_r <= cfg_wdata;
        rtgc_pkg::REG_EXTENT_Z: cfg_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign clamp_x = (cfg_x_r > EXT_CAP) ? EXT_CAP : cfg_x_r;
  assign clamp_y = (cfg_y_r > EXT_CAP) ? EXT_CAP : cfg_y_r;
  assign clamp_z = (cfg_z_r > EXT_CAP) ? EXT_CAP : cfg_z_r;

  always_comb begin
    if (ext_z_r >= ext_x_r && ext_z_r >= ext_y_r) begin
      pick_axis = AXIS_Z;
    end else if (ext_y_r >= ext_x_r && ext_y_r >= ext_z_r) begin
      pick_axis = AXIS_Y;
    end else begin
      pick_axis = AXIS_X;
    end
  end

  always_comb begin
    case (pick_axis)
      AXIS_X: begin
        pick_ext = ext_x_r;
        pick_oa  = ext_y_r;
        pick_ob  = ext_z_r;
      end
      AXIS_Y: begin
        pick_ext = ext_y_r;
        pick_oa  = ext_x_r;
        pick_ob  = ext_z_r;
      end
      default: begin
        pick_ext = ext_z_r;
        pick_oa  = ext_x_r;
        pick_ob  = ext_y_r;
      end
    endcase
  end

  always_comb begin
    case (axis_r)
      AXIS_X:  cur_ext = ext_x_r;
      AXIS_Y:  cur_ext = ext_y_r;
      default: cur_ext = ext_z_r;
    endcase
  end

  assign trial_sq  = PROD_W'(d_r) * PROD_W'(d_r);
  assign step_prod = PROD_W'(hi_r) * PROD_W'(nq_r);
  assign too_large = SIZE_W'(rank_r) >= size_r;

  assign sdiv_dividend = (cmd.sdiv_sel == rtgc_pkg::SDIV_EXTENT) ? cur_ext : n_r;
  assign sdiv_divisor  = (cmd.sdiv_sel == rtgc_pkg::SDIV_EXTENT) ? p_r : d_r;

  rtgc_div #(
    .DIVIDEND_W (EXT_W),
    .DIVISOR_W  (EXT_W),
    .QUOT_W     (QUOT_W)
  ) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sdiv_start),
    .dividend (sdiv_dividend),
    .divisor  (sdiv_divisor),
    .quot     (sdiv_quot),
    .rem      (sdiv_rem),
    .done     (sdiv_done)
  );

  rtgc_div #(
    .DIVIDEND_W (SIZE_W),
    .DIVISOR_W  (SIZE_W),
    .QUOT_W     (QUOT_W)
  ) u_rdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rdiv_start),
    .dividend (SIZE_W'(rank_r)),
    .divisor  (csize_r),
    .quot     (rdiv_quot),
    .rem      (rdiv_rem),
    .done     (rdiv_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rank_r  <= in_node_rank;
      ext_x_r <= clamp_x;
      ext_y_r <= clamp_y;
      ext_z_r <= clamp_z;
      crd_x_r <= '0;
      crd_y_r <= '0;
      crd_z_r <= '0;
    end
    if (cmd.size1) begin
      prod_r <= PROD_W'(ext_x_r) * PROD_W'(ext_y_r);
    end
    if (cmd.size2) begin
      size_r <= SIZE_W'(prod_r) * SIZE_W'(ext_z_r);
    end
    if (cmd.check) begin
      flag_r <= too_large;
    end
    if (cmd.pick) begin
      axis_r <= pick_axis;
      n_r    <= pick_ext;
      p_r    <= rtgc_pkg::EXT_ONE;
      d_r    <= rtgc_pkg::TRIAL_TWO;
      dhi_r  <= 1'b0;
      prod_r <= PROD_W'(pick_oa) * PROD_W'(pick_ob);
    end
    if (cmd.half) begin
      if (!n_r[0]) begin
        p_r <= rtgc_pkg::TRIAL_TWO;
        n_r <= n_r >> 1;
      end else begin
        d_r <= rtgc_pkg::TRIAL_THREE;
      end
    end
    if (cmd.fstep) begin
      if (sdiv_rem == '0) begin
        p_r <= d_r;
        n_r <= sdiv_quot;
      end else if (d_r == rtgc_pkg::TRIAL_THREE) begin
        d_r   <= rtgc_pkg::TRIAL_FIVE;
        dhi_r <= 1'b0;
      end else if (!dhi_r) begin
        d_r   <= d_r + rtgc_pkg::PAIR_STEP;
        dhi_r <= 1'b1;
      end else begin
        d_r   <= d_r + rtgc_pkg::WHEEL_STEP;
        dhi_r <= 1'b0;
      end
    end
    if (cmd.fend && n_r > rtgc_pkg::PRIME_FLOOR) begin
      p_r <= n_r;
    end
    if (cmd.capture_nq) begin
      nq_r <= sdiv_quot;
    end
    if (cmd.csize) begin
      csize_r <= SIZE_W'(nq_r) * SIZE_W'(prod_r);
    end
    if (cmd.capture_hi) begin
      hi_r   <= rdiv_quot;
      rank_r <= rdiv_rem[RANK_W-1:0];
    end
    if (cmd.mul) begin
      step_r <= step_prod[EXT_W-1:0];
    end
    if (cmd.update) begin
      case (axis_r)
        AXIS_X: begin
          crd_x_r <= crd_x_r + step_r;
          ext_x_r <= nq_r;
        end
        AXIS_Y: begin
          crd_y_r <= crd_y_r + step_r;
          ext_y_r <= nq_r;
        end
        default: begin
          crd_z_r <= crd_z_r + step_r;
          ext_z_r <= nq_r;
        end
      endcase
      size_r <= csize_r;
    end
    if (cmd.emit) begin
      out_x_r    <= crd_x_r[COORD_W-1:0];
      out_y_r    <= crd_y_r[COORD_W-1:0];
      out_z_r    <= crd_z_r[COORD_W-1:0];
      out_flag_r <= flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.too_large = too_large;
  assign status.size_one  = size_r == SIZE_W'(1);
  assign status.d_is_two  = d_r == rtgc_pkg::TRIAL_TWO;
  assign status.try_ok    = (d_r == rtgc_pkg::TRIAL_THREE) || dhi_r ||
                            (trial_sq <= PROD_W'(n_r));
  assign status.sdiv_done = sdiv_done;
  assign status.rdiv_done = rdiv_done;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_coord_x        = out_x_r;
  assign out_coord_y        = out_y_r;
  assign out_coord_z        = out_z_r;
  assign out_rank_too_large = out_flag_r;

endmodule

`default_nettype wire

### hdl/rtgc_ctrl.sv
// ----------------------------------------------------------------------------
// Rank to grid coordinates: controller
// Sequences the size product, the per-level prime factor search, extent and
// rank division and coordinate update, then hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rtgc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rtgc_pkg::status_t status,
  output rtgc_pkg::cmd_t         cmd
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_SIZE1  = 16'h0002,
    S_SIZE2  = 16'h0004,
    S_CHECK  = 16'h0008,
    S_PICK   = 16'h0010,
    S_FTRY   = 16'h0020,
    S_FWAIT  = 16'h0040,
    S_FEND   = 16'h0080,
    S_ESTART = 16'h0100,
    S_EWAIT  = 16'h0200,
    S_CSIZE  = 16'h0400,
    S_RSTART = 16'h0800,
    S_RWAIT  = 16'h1000,
    S_MUL    = 16'h2000,
    S_UPD    = 16'h4000,
    S_OUT    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SIZE1;
        end
      end
      S_SIZE1: begin
        cmd.size1 = 1'b1;
        state_nxt = S_SIZE2;
      end
      S_SIZE2: begin
        cmd.size2 = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.too_large || status.size_one) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_FTRY;
      end
      S_FTRY: begin
        if (status.d_is_two) begin
          cmd.half = 1'b1;
        end else if (status.try_ok) begin
          cmd.sdiv_start = 1'b1;
          cmd.sdiv_sel   = rtgc_pkg::SDIV_RESIDUE;
          state_nxt      = S_FWAIT;
        end else begin
          state_nxt = S_FEND;
        end
      end
      S_FWAIT: begin
        if (status.sdiv_done) begin
          cmd.fstep = 1'b1;
          state_nxt = S_FTRY;
        end
      end
      S_FEND: begin
        cmd.fend  = 1'b1;
        state_nxt = S_ESTART;
      end
      S_ESTART: begin
        cmd.sdiv_start = 1'b1;
        cmd.sdiv_sel   = rtgc_pkg::SDIV_EXTENT;
        state_nxt      = S_EWAIT;
      end
      S_EWAIT: begin
        if (status.sdiv_done) begin
          cmd.capture_nq = 1'b1;
          state_nxt      = S_CSIZE;
        end
      end
      S_CSIZE: begin
        cmd.csize = 1'b1;
        state_nxt = S_RSTART;
      end
      S_RSTART: begin
        cmd.rdiv_start = 1'b1;
        state_nxt      = S_RWAIT;
      end
      S_RWAIT: begin
        if (status.rdiv_done) begin
          cmd.capture_hi = 1'b1;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = state_r == S_IDLE;

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Rank to grid coordinates: testbench
// Drives node ranks through the valid/ready input channel and checks every
// result transfer against a predictor that peels off the largest prime factor
// of the largest extent, level by level. The extents are rewritten between
// phases, covering empty, single-position, saturated, prime and tied grids.
// Both sides idle at random, with one steady phase and one long output stall.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_IDX_W = rtgc_pkg::REG_IDX_W;
  localparam int EXT_W = rtgc_pkg::EXT_W;
  localparam int COORD_W = rtgc_pkg::COORD_W;
  localparam int RANK_W = rtgc_pkg::RANK_W;

  localparam int GRID_MAX = 1024;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam longint unsigned RANK_SPAN = 64'd1 << RANK_W;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               too_large;
  } placement_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [EXT_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [RANK_W-1:0]    in_node_rank = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   out_coord_x;
  logic [COORD_W-1:0]   out_coord_y;
  logic [COORD_W-1:0]   out_coord_z;
  logic                 out_rank_too_large;

  logic [EXT_W-1:0]  extent_reg [3];
  logic [RANK_W-1:0] rank_queue [$];
  placement_t        placement_queue [$];
  bit                steady = 1'b0;
  bit                hold_req = 1'b0;
  bit                rank_taken = 1'b0;
  int                hold_left = 0;
  int                mismatches = 0;
  int                quiet_cycles = 0;

  rank_to_grid_coordinates_core #(.MAX_EXTENT(GRID_MAX)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_node_rank       (in_node_rank),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_coord_x        (out_coord_x),
    .out_coord_y        (out_coord_y),
    .out_coord_z        (out_coord_z),
    .out_rank_too_large (out_rank_too_large)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned clamped(input int axis);
    if (extent_reg[axis] > GRID_MAX) begin
      return GRID_MAX;
    end
    return extent_reg[axis];
  endfunction

  function automatic longint unsigned grid_size();
    return clamped(0) * clamped(1) * clamped(2);
  endfunction

  function automatic longint unsigned top_prime(input longint unsigned value);
    longint unsigned n;
    longint unsigned p;
    longint unsigned i;
    n = value;
    p = 1;
    if (n < 2) begin
      return 1;
    end
    while (n % 2 == 0) begin
      p = 2;
      n = n / 2;
    end
    while (n % 3 == 0) begin
      p = 3;
      n = n / 3;
    end
    for (i = 5; i * i <= n; i += 6) begin
      while (n % i == 0) begin
        p = i;
        n = n / i;
      end
      while (n % (i + 2) == 0) begin
        p = i + 2;
        n = n / (i + 2);
      end
    end
    if (n > 4) begin
      p = n;
    end
    return p;
  endfunction

  function automatic placement_t place_rank(input logic [RANK_W-1:0] rank);
    longint unsigned ext [3];
    longint unsigned crd [3];
    longint unsigned left;
    longint unsigned size;
    longint unsigned sub;
    longint unsigned p;
    int              axis;
    placement_t      res;
    res = '0;
    for (axis = 0; axis < 3; axis++) begin
      ext[axis] = clamped(axis);
      crd[axis] = 0;
    end
    size = ext[0] * ext[1] * ext[2];
    left = rank;
    if (left >= size) begin
      res.too_large = 1'b1;
      return res;
    end
    while (size > 1) begin
      if (ext[2] >= ext[0] && ext[2] >= ext[1]) begin
        axis = 2;
      end else if (ext[1] >= ext[0] && ext[1] >= ext[2]) begin
        axis = 1;
      end else begin
        axis = 0;
      end
      p = top_prime(ext[axis]);
      if (p < 2) begin
        break;
      end
      sub = size / p;
      crd[axis] += (left / sub) * (ext[axis] / p);
      left = left % sub;
      ext[axis] = ext[axis] / p;
      size = sub;
    end
    res.x = crd[0][COORD_W-1:0];
    res.y = crd[1][COORD_W-1:0];
    res.z = crd[2][COORD_W-1:0];
    return res;
  endfunction

  function automatic logic [RANK_W-1:0] pick_rank();
    longint unsigned size;
    int              roll;
    size = grid_size();
    roll = $urandom_range(99);
    if (size == 0 || roll < 5) begin
      return RANK_W'($urandom());
    end
    if (roll < 15) begin
      if (size >= RANK_SPAN) begin
        return RANK_W'($urandom());
      end
      if (roll < 9) begin
        return RANK_W'(size);
      end
      return RANK_W'($urandom_range(32'(RANK_SPAN - 1), 32'(size)));
    end
    return RANK_W'($urandom_range(32'(size - 1), 0));
  endfunction

  function automatic logic [EXT_W-1:0] small_extent();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) begin
      return '0;
    end
    if (roll < 15) begin
      return EXT_W'($urandom_range(64, 17));
    end
    return EXT_W'($urandom_range(16, 1));
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [EXT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      rtgc_pkg::REG_EXTENT_X: begin
        extent_reg[0] = value;
      end
      rtgc_pkg::REG_EXTENT_Y: begin
        extent_reg[1] = value;
      end
      rtgc_pkg::REG_EXTENT_Z: begin
        extent_reg[2] = value;
      end
      default: begin
      end
    endcase
  endtask

  task automatic end_write();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(input logic [EXT_W-1:0] ex, input logic [EXT_W-1:0] ey,
                          input logic [EXT_W-1:0] ez);
    write_reg(rtgc_pkg::REG_EXTENT_X, ex);
    write_reg(rtgc_pkg::REG_EXTENT_Y, ey);
    write_reg(rtgc_pkg::REG_EXTENT_Z, ez);
    end_write();
  endtask

  task automatic drain();
    while (rank_queue.size() != 0 || in_valid || placement_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Input driver: a new rank is offered only once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || rank_taken) begin
      rank_taken = 1'b0;
      if (rank_queue.size() > 0 && (steady || $urandom_range(99) >= 9)) begin
        in_valid <= 1'b1;
        in_node_rank <= rank_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_node_rank <= RANK_W'($urandom());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || $urandom_range(99) >= 9;
    end
  end

  always @(posedge clk) begin : monitor
    placement_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        placement_queue.push_back(place_rank(in_node_rank));
        rank_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (placement_queue.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer expected none, got (%0d, %0d, %0d, %0d)", $time,
                   out_coord_x, out_coord_y, out_coord_z, out_rank_too_large);
        end else begin
          want = placement_queue.pop_front();
          compare_field("coord_x", want.x, out_coord_x);
          compare_field("coord_y", want.y, out_coord_y);
          compare_field("coord_z", want.z, out_coord_z);
          compare_field("rank_too_large", want.too_large, out_rank_too_large);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned size;
    int              phase;
    int              count;
    int              issued;
    extent_reg[0] = rtgc_pkg::EXT_ONE;
    extent_reg[1] = rtgc_pkg::EXT_ONE;
    extent_reg[2] = rtgc_pkg::EXT_ONE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-position grid straight after reset.
    rank_queue.push_back('0);
    rank_queue.push_back(30'd1);
    rank_queue.push_back('1);
    drain();

    // A write to the spare index must leave the grid untouched.
    write_reg(REG_SPARE, '1);
    end_write();
    rank_queue.push_back('0);
    rank_queue.push_back(30'd1);
    drain();

    // Saturated extents: the grid spans every rank.
    set_grid('1, 11'd1024, 11'd1024);
    rank_queue.push_back('0);
    rank_queue.push_back('1);
    rank_queue.push_back(30'h2AAAAAAA);
    rank_queue.push_back(30'h15555555);
    drain();

    set_grid('0, 11'd5, 11'd7);
    rank_queue.push_back('0);
    rank_queue.push_back(30'd34);
    drain();

    set_grid(11'd1021, 11'd1019, 11'd1013);
    size = grid_size();
    rank_queue.push_back('0);
    rank_queue.push_back(RANK_W'(size - 1));
    rank_queue.push_back(RANK_W'(size));
    rank_queue.push_back(30'd123456789);
    drain();

    set_grid(11'd6, 11'd6, 11'd6);
    rank_queue.push_back('0);
    rank_queue.push_back(30'd215);
    rank_queue.push_back(30'd100);
    drain();

    set_grid(11'd8, 11'd8, 11'd3);
    rank_queue.push_back(30'd37);
    rank_queue.push_back(30'd191);
    drain();

    set_grid(11'd5, 11'd3, 11'd5);
    rank_queue.push_back(30'd29);
    rank_queue.push_back(30'd74);
    drain();

    phase = 0;
    issued = 0;
    while (issued < 1175) begin
      if (phase % 5 == 4) begin
        set_grid(EXT_W'($urandom_range(2047, 1)), EXT_W'($urandom_range(2047, 1)),
                 EXT_W'($urandom_range(2047, 1)));
        count = 20;
      end else begin
        set_grid(small_extent(), small_extent(), small_extent());
        count = 100;
      end
      steady = (phase == 2);
      repeat (count) rank_queue.push_back(pick_rank());
      issued += count;
      if (phase == 1) begin
        hold_req = 1'b1;
      end
      drain();
      phase++;
    end
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
